FILE: hw/rtl/slot_array_doubly_linked_list_defines.svh
`ifndef SLOT_ARRAY_DOUBLY_LINKED_LIST_DEFINES_SVH
`define SLOT_ARRAY_DOUBLY_LINKED_LIST_DEFINES_SVH

// Check cons in the same cycle as ante; needs clk and rst_n in scope.
`define SADLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante; needs clk and rst_n in scope.
`define SADLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sadll_pkg.sv
package sadll_pkg;

  localparam int SLOTS        = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int RESULT_CAP   = 16;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int K_W    = $clog2(RESULT_CAP);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_TYPE_W  = 2;
  localparam int IN_VALUE_W = 64;
  localparam int IN_POS_W   = 4;
  localparam int OUT_STAT_W = 2;
  localparam int OUT_SLOT_W = 4;
  localparam int OUT_VAL_W  = 64;
  localparam int OUT_CNT_W  = 5;

  typedef logic [SLOT_W-1:0]       slot_idx_t;
  typedef logic [LINK_W-1:0]       link_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [K_W-1:0]          k_t;
  typedef logic [QPTR_W-1:0]       qptr_t;
  typedef logic [QCNT_W-1:0]       qcnt_t;
  typedef logic [OUT_SLOT_W-1:0]   out_slot_t;
  typedef logic [OUT_VAL_W-1:0]    out_val_t;
  typedef logic [OUT_CNT_W-1:0]    out_cnt_t;

  localparam link_t NONE_LINK = link_t'(SLOTS);
  localparam link_t FULL_LIVE = link_t'(SLOTS);
  localparam k_t    K_LAST    = k_t'(RESULT_CAP - 1);

  typedef enum logic [IN_TYPE_W-1:0] {
    REQ_ADD_FIRST = 2'd0,
    REQ_ADD_AFTER = 2'd1,
    REQ_ADD_LAST  = 2'd2,
    REQ_TRAVERSE  = 2'd3
  } req_kind_t;

  typedef enum logic [OUT_STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LINK_RD,
    B_WR1,
    B_WR2,
    B_TRAV_RD,
    B_TRAV_EMIT
  } back_state_t;

  typedef struct packed {
    req_kind_t             kind;
    payload_t              value;
    logic [IN_POS_W-1:0]   position;
    logic                  pos_in_range;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

endpackage

FILE: hw/rtl/sadll_queue.sv
module sadll_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sadll_pkg::q_wr_t  wr,
  input  logic              pop,
  output sadll_pkg::q_rd_t  rd,
  output logic              full
);

  sadll_pkg::cmd_t  entry_r [sadll_pkg::QDEPTH];
  sadll_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  sadll_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  sadll_pkg::qcnt_t cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == sadll_pkg::qcnt_t'(sadll_pkg::QDEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.cmd   = entry_r[rd_ptr_r];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sadll_pkg::qptr_t'(sadll_pkg::QDEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sadll_pkg::qptr_t'(sadll_pkg::QDEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr.cmd;
    end
  end

endmodule

FILE: hw/rtl/sadll_front.sv
`include "slot_array_doubly_linked_list_defines.svh"

module sadll_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sadll_pkg::IN_TYPE_W-1:0]     in_req_type,
  input  logic [sadll_pkg::IN_VALUE_W-1:0]    in_item_value,
  input  logic [sadll_pkg::IN_POS_W-1:0]      in_position,
  input  logic                                q_full,
  output sadll_pkg::q_wr_t                    q_wr
);

  logic full_seen_r;

  assign busy = q_full;

  always_comb begin
    q_wr.push             = start && !q_full;
    q_wr.cmd.kind         = sadll_pkg::req_kind_t'(in_req_type);
    q_wr.cmd.value        = in_item_value[sadll_pkg::PAYLOAD_BITS-1:0];
    q_wr.cmd.position     = in_position;
    q_wr.cmd.pos_in_range = (int'(in_position) < sadll_pkg::SLOTS);
  end

  // track a beat offered while the queue is full, for the stall check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_seen_r <= 1'b0;
    end else begin
      full_seen_r <= start && q_full;
    end
  end

  `SADLL_ASSERT_NOW(a_no_push_when_full, q_full, !q_wr.push,
                    "front pushed into a full queue")
  `SADLL_ASSERT_NOW(a_stall_holds_busy, full_seen_r && start && q_full, busy,
                    "busy dropped while queue stayed full")
  `SADLL_ASSERT_NOW(a_push_is_accept, q_wr.push, start && !busy,
                    "push without an accepted beat")

endmodule

FILE: hw/rtl/sadll_back.sv
`include "slot_array_doubly_linked_list_defines.svh"

module sadll_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sadll_pkg::q_rd_t                  q_rd,
  output logic                              pop,
  output logic                              out_valid,
  output logic [sadll_pkg::OUT_STAT_W-1:0]  out_status,
  output logic [sadll_pkg::OUT_SLOT_W-1:0]  out_slot,
  output logic [sadll_pkg::OUT_VAL_W-1:0]   out_value_out,
  output logic [sadll_pkg::OUT_CNT_W-1:0]   out_element_count,
  output logic                              out_last_of_run
);

  sadll_pkg::back_state_t state_r, state_nxt;

  logic [sadll_pkg::SLOTS-1:0] used_r, used_nxt;
  sadll_pkg::link_t            head_r, head_nxt;
  sadll_pkg::link_t            tail_r, tail_nxt;
  sadll_pkg::link_t            live_r, live_nxt;

  sadll_pkg::cmd_t      cmd_r, cmd_nxt;
  sadll_pkg::slot_idx_t new_r, new_nxt;
  sadll_pkg::link_t     prev_r, prev_nxt;
  sadll_pkg::link_t     after_r, after_nxt;
  sadll_pkg::link_t     cur_r, cur_nxt;
  sadll_pkg::k_t        k_r, k_nxt;

  logic                 out_valid_r, out_valid_nxt;
  sadll_pkg::status_t   out_status_r, out_status_nxt;
  sadll_pkg::out_slot_t out_slot_r, out_slot_nxt;
  sadll_pkg::out_val_t  out_value_r, out_value_nxt;
  sadll_pkg::out_cnt_t  out_count_r, out_count_nxt;
  logic                 out_last_r, out_last_nxt;

  sadll_pkg::link_t     next_mem [sadll_pkg::SLOTS];
  sadll_pkg::payload_t  pay_mem  [sadll_pkg::SLOTS];
  sadll_pkg::link_t     nl_rd_r;
  sadll_pkg::payload_t  pay_rd_r;

  logic                 nm_we, pay_we;
  sadll_pkg::slot_idx_t nm_waddr, rd_addr;
  sadll_pkg::link_t     nm_wdata;

  sadll_pkg::slot_idx_t free_idx;
  sadll_pkg::link_t     pick_prev, after_w;
  logic                 pos_used, trav_last;

  always_comb begin
    free_idx = '0;
    for (int i = sadll_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = sadll_pkg::slot_idx_t'(i);
      end
    end
  end

  always_comb begin
    pos_used = q_rd.cmd.pos_in_range &&
               used_r[sadll_pkg::slot_idx_t'(q_rd.cmd.position)];
    case (q_rd.cmd.kind)
      sadll_pkg::REQ_ADD_AFTER: begin
        pick_prev = sadll_pkg::link_t'(q_rd.cmd.position);
      end
      sadll_pkg::REQ_ADD_LAST: begin
        pick_prev = (head_r != sadll_pkg::NONE_LINK && tail_r != sadll_pkg::NONE_LINK)
                    ? tail_r : sadll_pkg::NONE_LINK;
      end
      default: begin
        pick_prev = sadll_pkg::NONE_LINK;
      end
    endcase
    after_w   = (prev_r == sadll_pkg::NONE_LINK) ? head_r : nl_rd_r;
    trav_last = (nl_rd_r >= sadll_pkg::NONE_LINK) || (k_r == sadll_pkg::K_LAST);
    rd_addr   = (state_r == sadll_pkg::B_TRAV_RD) ? sadll_pkg::slot_idx_t'(cur_r)
                                                  : sadll_pkg::slot_idx_t'(prev_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sadll_pkg::B_IDLE: begin
        if (q_rd.valid) begin
          if (q_rd.cmd.kind == sadll_pkg::REQ_TRAVERSE) begin
            state_nxt = (head_r == sadll_pkg::NONE_LINK) ? sadll_pkg::B_IDLE
                                                         : sadll_pkg::B_TRAV_RD;
          end else if (live_r == sadll_pkg::FULL_LIVE) begin
            state_nxt = sadll_pkg::B_IDLE;
          end else if (q_rd.cmd.kind == sadll_pkg::REQ_ADD_AFTER && !pos_used) begin
            state_nxt = sadll_pkg::B_IDLE;
          end else if (pick_prev != sadll_pkg::NONE_LINK) begin
            state_nxt = sadll_pkg::B_LINK_RD;
          end else begin
            state_nxt = sadll_pkg::B_WR1;
          end
        end
      end
      sadll_pkg::B_LINK_RD:   state_nxt = sadll_pkg::B_WR1;
      sadll_pkg::B_WR1:       state_nxt = sadll_pkg::B_WR2;
      sadll_pkg::B_WR2:       state_nxt = sadll_pkg::B_IDLE;
      sadll_pkg::B_TRAV_RD:   state_nxt = sadll_pkg::B_TRAV_EMIT;
      sadll_pkg::B_TRAV_EMIT: begin
        state_nxt = trav_last ? sadll_pkg::B_IDLE : sadll_pkg::B_TRAV_RD;
      end
      default:                state_nxt = sadll_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    used_nxt       = used_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    live_nxt       = live_r;
    cmd_nxt        = cmd_r;
    new_nxt        = new_r;
    prev_nxt       = prev_r;
    after_nxt      = after_r;
    cur_nxt        = cur_r;
    k_nxt          = k_r;
    nm_we          = 1'b0;
    nm_waddr       = new_r;
    nm_wdata       = after_w;
    pay_we         = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = sadll_pkg::ST_OK;
    out_slot_nxt   = '0;
    out_value_nxt  = '0;
    out_count_nxt  = sadll_pkg::out_cnt_t'(live_r);
    out_last_nxt   = 1'b1;
    case (state_r)
      sadll_pkg::B_IDLE: begin
        if (q_rd.valid) begin
          pop      = 1'b1;
          cmd_nxt  = q_rd.cmd;
          new_nxt  = free_idx;
          prev_nxt = pick_prev;
          cur_nxt  = head_r;
          k_nxt    = '0;
          if (q_rd.cmd.kind == sadll_pkg::REQ_TRAVERSE) begin
            if (head_r == sadll_pkg::NONE_LINK) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = sadll_pkg::ST_EMPTY;
            end
          end else if (live_r == sadll_pkg::FULL_LIVE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sadll_pkg::ST_FULL;
          end else if (q_rd.cmd.kind == sadll_pkg::REQ_ADD_AFTER && !pos_used) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = sadll_pkg::ST_BAD_POS;
          end
        end
      end
      sadll_pkg::B_WR1: begin
        nm_we            = 1'b1;
        pay_we           = 1'b1;
        used_nxt[new_r]  = 1'b1;
        after_nxt        = after_w;
      end
      sadll_pkg::B_WR2: begin
        if (prev_r != sadll_pkg::NONE_LINK) begin
          nm_we    = 1'b1;
          nm_waddr = sadll_pkg::slot_idx_t'(prev_r);
          nm_wdata = sadll_pkg::link_t'(new_r);
        end else begin
          head_nxt = sadll_pkg::link_t'(new_r);
        end
        if (after_r == sadll_pkg::NONE_LINK) begin
          tail_nxt = sadll_pkg::link_t'(new_r);
        end
        live_nxt      = live_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = sadll_pkg::out_slot_t'(new_r);
        out_count_nxt = sadll_pkg::out_cnt_t'(live_r + 1'b1);
      end
      sadll_pkg::B_TRAV_EMIT: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = sadll_pkg::out_slot_t'(cur_r);
        out_value_nxt = sadll_pkg::out_val_t'(pay_rd_r);
        out_last_nxt  = trav_last;
        if (!trav_last) begin
          cur_nxt = nl_rd_r;
          k_nxt   = k_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sadll_pkg::B_IDLE;
      used_r      <= '0;
      head_r      <= sadll_pkg::NONE_LINK;
      tail_r      <= sadll_pkg::NONE_LINK;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    new_r        <= new_nxt;
    prev_r       <= prev_nxt;
    after_r      <= after_nxt;
    cur_r        <= cur_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      next_mem[nm_waddr] <= nm_wdata;
    end
    if (pay_we) begin
      pay_mem[new_r] <= cmd_r.value;
    end
    nl_rd_r  <= next_mem[rd_addr];
    pay_rd_r <= pay_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_value_out     = out_value_r;
  assign out_element_count = out_count_r;
  assign out_last_of_run   = out_last_r;

  `SADLL_ASSERT_NOW(a_count_matches_used, state_r == sadll_pkg::B_IDLE,
                    live_r == $countones(used_r), "element count disagrees with used marks")
  `SADLL_ASSERT_NOW(a_head_iff_nonempty, state_r == sadll_pkg::B_IDLE,
                    (head_r == sadll_pkg::NONE_LINK) == (live_r == '0),
                    "head and element count disagree")
  `SADLL_ASSERT_NOW(a_new_slot_free, state_r == sadll_pkg::B_WR1, !used_r[new_r],
                    "insert into a slot already in use")
  `SADLL_ASSERT_NOW(a_run_continues, out_valid_r && !out_last_r,
                    state_r == sadll_pkg::B_TRAV_RD, "run ended without a last beat")
  `SADLL_ASSERT_NEXT(a_wr2_emits, state_r == sadll_pkg::B_WR2,
                     out_valid_r && out_last_r, "insert gave no result beat")

endmodule

FILE: hw/rtl/slot_array_doubly_linked_list.sv
// Channel   Handshake             Beat
// input     start / busy          in_req_type, in_item_value, in_position
// result    out_valid (1 cycle)   out_status, out_slot, out_value_out,
//                                 out_element_count, out_last_of_run
//
// A 2-entry queue sits between the request decoder and the list sequencer.
// Sequencer steps per request: a refused add or empty traverse is answered from idle;
// add at the head writes the new slot, then the head; add after a slot or at the tail
// does a link read and two link writes; traverse does one link/payload read per element.
// Reset (rst_n low, synchronous) empties the list at once; no clearing pass.
// busy rises only when the queue is full; results cannot be held off.
module slot_array_doubly_linked_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [sadll_pkg::IN_TYPE_W-1:0]   in_req_type,
  input  logic [sadll_pkg::IN_VALUE_W-1:0]  in_item_value,
  input  logic [sadll_pkg::IN_POS_W-1:0]    in_position,
  output logic                              out_valid,
  output logic [sadll_pkg::OUT_STAT_W-1:0]  out_status,
  output logic [sadll_pkg::OUT_SLOT_W-1:0]  out_slot,
  output logic [sadll_pkg::OUT_VAL_W-1:0]   out_value_out,
  output logic [sadll_pkg::OUT_CNT_W-1:0]   out_element_count,
  output logic                              out_last_of_run
);

  sadll_pkg::q_wr_t q_wr;
  sadll_pkg::q_rd_t q_rd;
  logic             q_full;
  logic             q_pop;

  sadll_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_item_value (in_item_value),
    .in_position   (in_position),
    .q_full        (q_full),
    .q_wr          (q_wr)
  );

  sadll_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .pop   (q_pop),
    .rd    (q_rd),
    .full  (q_full)
  );

  sadll_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rd              (q_rd),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_value_out     (out_value_out),
    .out_element_count (out_element_count),
    .out_last_of_run   (out_last_of_run)
  );

endmodule
